FILE: hdl/lmsf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// lmsf_pkg
// Shared widths, reset values and register codes of the LMS adaptive FIR core.
// ============================================================================
package lmsf_pkg;

    localparam int TAPS_DEFAULT = 32;

    localparam int DATA_W     = 16;   // Q1.15 samples, desired, y, error
    localparam int COEF_W     = 32;   // Q2.30 coefficients
    localparam int STEP_W     = 16;   // Q0.16 step size
    localparam int TAP_CNT_W  = 6;
    localparam int PROD_W     = DATA_W + COEF_W;
    localparam int TDATA_W    = 2 * DATA_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0]    STEP_RESET  = STEP_W'(328);
    localparam logic [TAP_CNT_W-1:0] COUNT_RESET = TAP_CNT_W'(32);

    localparam int SAMP_MAX = 32767;
    localparam int SAMP_MIN = -32768;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = CFG_IDX_W'(1);

endpackage

FILE: hdl/lms_adaptive_fir_core.sv
`timescale 1ns / 1ps
// ============================================================================
// lms_adaptive_fir_core
// LMS adaptive FIR filter with one shared 16x32 multiplier under a sequencer.
// ============================================================================
// Each request carries a new sample and a desired value; the block returns
// one result with the filter output y and the error d - y, both saturated
// Q1.15, then adapts the active coefficients (Q2.30, saturating) by
// step_size * error * tap sample. One shared multiplier walks the active
// taps once for the dot product and once for the coefficient update, with
// a drain after each pass for the registered memory read and the product
// register. s_tready is high only while the sequencer is idle; a finished
// result waits in an output register. The delay line is a circular buffer
// with a fill count and the coefficients carry one valid bit each, so no
// clearing pass follows reset. Writing tap_count zeroes the coefficients
// at and beyond the new count; write configuration only while the block is
// idle.
module lms_adaptive_fir_core #(
    parameter int TAPS = lmsf_pkg::TAPS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lmsf_pkg::TDATA_W-1:0]         s_tdata,    // new_sample, desired
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lmsf_pkg::TDATA_W-1:0]         m_tdata,    // filter_output, error_value
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lmsf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lmsf_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DATA_W = lmsf_pkg::DATA_W;
    localparam int COEF_W = lmsf_pkg::COEF_W;
    localparam int PROD_W = lmsf_pkg::PROD_W;
    localparam int TCN_W  = lmsf_pkg::TAP_CNT_W;
    localparam int IDX_W  = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);
    localparam int TCW    = (CNT_W > TCN_W) ? CNT_W : TCN_W;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam int RND_W  = ACC_W - 30;

    localparam logic signed [ACC_W-1:0]  ACC_HALF = ACC_W'(1) << 29;
    localparam logic signed [PROD_W-1:0] DLT_HALF = PROD_W'(1) << 15;
    localparam logic signed [RND_W-1:0]  RND_MAX  = RND_W'(lmsf_pkg::SAMP_MAX);
    localparam logic signed [RND_W-1:0]  RND_MIN  = RND_W'(lmsf_pkg::SAMP_MIN);
    localparam logic signed [DATA_W:0]   ERR_MAX  = (DATA_W + 1)'(lmsf_pkg::SAMP_MAX);
    localparam logic signed [DATA_W:0]   ERR_MIN  = (DATA_W + 1)'(lmsf_pkg::SAMP_MIN);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DOT,
        S_DRAIN,
        S_ROUND,
        S_ERR,
        S_GAIN,
        S_GAIN_WB,
        S_UPD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [lmsf_pkg::STEP_W-1:0] step_reg;
    logic [TCN_W-1:0]            tap_count_reg;
    logic [CNT_W-1:0]            n_eff, n_new;
    logic [TCW-1:0]              tc_ext, tc_new_ext;

    // sequencer and pipeline control
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0] saddr_reg;
    logic [IDX_W-1:0] wp_reg, wp_inc;
    logic [CNT_W-1:0] fill_reg;
    logic             upd_pass_reg;
    logic             rd_vld_reg, mul_vld_reg;
    logic [IDX_W-1:0] idx_d1_reg, idx_d2_reg;
    logic [TAPS-1:0]  coef_valid_reg;
    logic             issue, in_acc, cfg_acc, last_issue, coef_we, out_load;

    // storage
    logic signed [DATA_W-1:0] samp_mem [TAPS];
    logic signed [COEF_W-1:0] coef_mem [TAPS];

    // datapath
    logic signed [DATA_W-1:0] samp_rd_reg;
    logic                     samp_ok_reg;
    logic signed [COEF_W-1:0] coef_rd_reg;
    logic                     coef_ok_reg;
    logic signed [COEF_W-1:0] coef_d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [DATA_W-1:0] d_reg, y_reg, e_reg;
    logic signed [COEF_W-1:0] g_reg;
    logic                     out_vld_reg;
    logic signed [DATA_W-1:0] out_y_reg, out_e_reg;

    logic signed [DATA_W-1:0] mul_a;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic signed [ACC_W-1:0]  acc_rnd;
    logic signed [RND_W-1:0]  acc_sh;
    logic signed [DATA_W-1:0] y_sat, e_sat;
    logic signed [DATA_W:0]   e_diff;
    logic signed [PROD_W-1:0] dlt_sum;
    logic signed [COEF_W-1:0] delta, c_sat;
    logic signed [COEF_W:0]   c_sum;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = {out_e_reg, out_y_reg};

    assign in_acc     = s_tvalid && s_tready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign issue      = (state_reg == S_DOT) || (state_reg == S_UPD);
    assign last_issue = (cnt_reg == n_eff - CNT_W'(1));
    assign coef_we    = mul_vld_reg && upd_pass_reg;
    assign out_load   = (state_reg == S_DONE) && (!out_vld_reg || m_tready);
    assign wp_inc     = (wp_reg == IDX_W'(TAPS - 1)) ? '0 : wp_reg + IDX_W'(1);

    // clamp tap count to 1..TAPS
    always_comb
    begin
        tc_ext     = TCW'(tap_count_reg);
        tc_new_ext = TCW'(cfg_data[TCN_W-1:0]);
        if (tc_ext == '0)
            n_eff = CNT_W'(1);
        else if (tc_ext > TCW'(TAPS))
            n_eff = CNT_W'(TAPS);
        else
            n_eff = CNT_W'(tc_ext);
        if (tc_new_ext == '0)
            n_new = CNT_W'(1);
        else if (tc_new_ext > TCW'(TAPS))
            n_new = CNT_W'(TAPS);
        else
            n_new = CNT_W'(tc_new_ext);
    end

    // shared multiplier operand select
    always_comb
    begin
        if (state_reg == S_GAIN)
        begin
            mul_a = e_reg;
            mul_b = COEF_W'(step_reg);
        end
        else
        begin
            mul_a = samp_ok_reg ? samp_rd_reg : '0;
            if (upd_pass_reg)
                mul_b = g_reg;
            else
                mul_b = coef_ok_reg ? coef_rd_reg : '0;
        end
        mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // rounding, saturation and coefficient update arithmetic
    always_comb
    begin
        acc_rnd = acc_reg + ACC_HALF;
        acc_sh  = acc_rnd[ACC_W-1:30];
        if (acc_sh > RND_MAX)
            y_sat = DATA_W'(lmsf_pkg::SAMP_MAX);
        else if (acc_sh < RND_MIN)
            y_sat = DATA_W'(lmsf_pkg::SAMP_MIN);
        else
            y_sat = acc_sh[DATA_W-1:0];

        e_diff = (DATA_W + 1)'(d_reg) - (DATA_W + 1)'(y_reg);
        if (e_diff > ERR_MAX)
            e_sat = DATA_W'(lmsf_pkg::SAMP_MAX);
        else if (e_diff < ERR_MIN)
            e_sat = DATA_W'(lmsf_pkg::SAMP_MIN);
        else
            e_sat = e_diff[DATA_W-1:0];

        dlt_sum = prod_reg + DLT_HALF;
        delta   = dlt_sum[PROD_W-1:16];
        c_sum   = (COEF_W + 1)'(coef_d_reg) + (COEF_W + 1)'(delta);
        if (c_sum[COEF_W] != c_sum[COEF_W-1])
            c_sat = c_sum[COEF_W] ? {1'b1, {(COEF_W - 1){1'b0}}}
                                  : {1'b0, {(COEF_W - 1){1'b1}}};
        else
            c_sat = c_sum[COEF_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_acc)
                    state_next = S_DOT;
            S_DOT, S_UPD:
                if (last_issue)
                    state_next = S_DRAIN;
            S_DRAIN:
                if (!rd_vld_reg && !mul_vld_reg)
                    state_next = upd_pass_reg ? S_DONE : S_ROUND;
            S_ROUND:   state_next = S_ERR;
            S_ERR:     state_next = S_GAIN;
            S_GAIN:    state_next = S_GAIN_WB;
            S_GAIN_WB: state_next = S_UPD;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // sequencer, control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= lmsf_pkg::STEP_RESET;
            tap_count_reg  <= lmsf_pkg::COUNT_RESET;
            cnt_reg        <= '0;
            saddr_reg      <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            upd_pass_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            mul_vld_reg    <= 1'b0;
            coef_valid_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_vld_reg  <= issue;
            mul_vld_reg <= rd_vld_reg;

            if (in_acc)
            begin
                wp_reg       <= wp_inc;
                saddr_reg    <= wp_inc;
                cnt_reg      <= '0;
                upd_pass_reg <= 1'b0;
                if (fill_reg != CNT_W'(TAPS))
                    fill_reg <= fill_reg + CNT_W'(1);
            end
            else if (state_reg == S_GAIN_WB)
            begin
                saddr_reg    <= wp_reg;
                cnt_reg      <= '0;
                upd_pass_reg <= 1'b1;
            end
            else if (issue)
            begin
                cnt_reg   <= cnt_reg + CNT_W'(1);
                saddr_reg <= (saddr_reg == '0) ? IDX_W'(TAPS - 1) : saddr_reg - IDX_W'(1);
            end

            if (coef_we)
                coef_valid_reg[idx_d2_reg] <= 1'b1;

            if (cfg_acc)
            begin
                unique case (cfg_index)
                    lmsf_pkg::REG_STEP_SIZE:
                        step_reg <= cfg_data[lmsf_pkg::STEP_W-1:0];
                    lmsf_pkg::REG_TAP_COUNT:
                    begin
                        tap_count_reg <= cfg_data[TCN_W-1:0];
                        for (int i = 0; i < TAPS; i++)
                        begin
                            if (CNT_W'(i) >= n_new)
                                coef_valid_reg[i] <= 1'b0;
                        end
                    end
                    default: ;  // drop writes to unknown registers
                endcase
            end

            if (out_load)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // delay line and coefficient memories
    always_ff @(posedge clk)
    begin
        if (in_acc)
            samp_mem[wp_inc] <= s_tdata[DATA_W-1:0];
        if (issue)
            samp_rd_reg <= samp_mem[saddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[idx_d2_reg] <= c_sat;
        if (issue)
            coef_rd_reg <= coef_mem[cnt_reg[IDX_W-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            samp_ok_reg <= (cnt_reg < fill_reg);
            coef_ok_reg <= coef_valid_reg[cnt_reg[IDX_W-1:0]];
            idx_d1_reg  <= cnt_reg[IDX_W-1:0];
        end
        if (rd_vld_reg)
        begin
            idx_d2_reg <= idx_d1_reg;
            coef_d_reg <= coef_ok_reg ? coef_rd_reg : '0;
        end
        prod_reg <= mul_out;

        if (in_acc)
        begin
            acc_reg <= '0;
            d_reg   <= s_tdata[2*DATA_W-1:DATA_W];
        end
        else if (mul_vld_reg && !upd_pass_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);

        if (state_reg == S_ROUND)
            y_reg <= y_sat;
        if (state_reg == S_ERR)
            e_reg <= e_sat;
        if (state_reg == S_GAIN_WB)
            g_reg <= prod_reg[COEF_W-1:0];

        if (out_load)
        begin
            out_y_reg <= y_reg;
            out_e_reg <= e_reg;
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("request taken while the tap pipeline is busy");

    a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (cnt_reg < n_eff))
        else $error("tap index beyond the active tap count");

    a_accept_starts_dot: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_DOT))
        else $error("accepted request did not start the dot-product pass");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result presented outside the completion step");

endmodule
